// ===== hw/rtl/rhfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhfs_pkg
// Shared types and constants of the radial heat step block.
// ----------------------------------------------------------------------------
package rhfs_pkg;

   localparam int VAL_W      = 32;
   localparam int MAX_POINTS = 4096;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int GAIN_W     = 32;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd21474836;
   localparam int RSP_DATA_W = 80;

   // one classified grid point, handed from the front to the back
   typedef struct packed {
      logic signed [VAL_W-1:0] x;     // newest sample
      logic signed [VAL_W-1:0] a;     // sample two points back
      logic signed [VAL_W-1:0] b;     // sample one point back
      logic [IDX_W-1:0]        k;     // index of the newest sample
      logic                    last;  // newest sample is the outermost point
   } task_type;

endpackage : rhfs_pkg
`default_nettype wire

// ===== hw/rtl/rhfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhfs_front
// Accepts grid samples, tracks the point count and the two previous samples.
// ----------------------------------------------------------------------------
module rhfs_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [rhfs_pkg::VAL_W-1:0] req_tdata,
   input  wire logic                       req_tlast,
   input  wire logic                       q_full,
   output logic                            q_push,
   output rhfs_pkg::task_type              q_task
);
   import rhfs_pkg::*;

   logic [VAL_W-1:0] older_ff, older_in;
   logic [VAL_W-1:0] newer_ff, newer_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             last;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign last       = req_tlast || (count_ff == IDX_W'(MAX_POINTS - 1));

   always_comb begin
      q_task.x    = req_tdata;
      q_task.a    = older_ff;
      q_task.b    = newer_ff;
      q_task.k    = count_ff;
      q_task.last = last;
      older_in    = older_ff;
      newer_in    = newer_ff;
      count_in    = count_ff;
      if (q_push) begin
         if (last) begin
            older_in = '0;
            newer_in = '0;
            count_in = '0;
         end else begin
            older_in = newer_ff;
            newer_in = req_tdata;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         count_ff <= '0;
      end else begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         count_ff <= count_in;
      end
   end

endmodule : rhfs_front
`default_nettype wire

// ===== hw/rtl/rhfs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhfs_queue
// Two-entry queue of classified points between the front and the back.
// ----------------------------------------------------------------------------
module rhfs_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rhfs_pkg::task_type push_task,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output rhfs_pkg::task_type head
);
   import rhfs_pkg::*;

   task_type   slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = pop ? !rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule : rhfs_queue
`default_nettype wire

// ===== hw/rtl/rhfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhfs_back
// Sequencer that computes the update of each point and the step error.
// ----------------------------------------------------------------------------
module rhfs_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rhfs_pkg::GAIN_W-1:0] gain,
   input  wire logic                        q_not_empty,
   input  wire rhfs_pkg::task_type          q_head,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [rhfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import rhfs_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_MULQ  = 4'd2;
   localparam logic [3:0] ST_BRACK = 4'd3;
   localparam logic [3:0] ST_GMUL1 = 4'd4;
   localparam logic [3:0] ST_GMUL2 = 4'd5;
   localparam logic [3:0] ST_APPLY = 4'd6;
   localparam logic [3:0] ST_SQ    = 4'd7;
   localparam logic [3:0] ST_ACC   = 4'd8;
   localparam logic [3:0] ST_EMIT  = 4'd9;
   localparam logic [3:0] ST_SQRT  = 4'd10;
   localparam logic [3:0] ST_EMITF = 4'd11;

   localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
   localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

   logic [3:0]        state_ff, state_in;
   task_type          task_ff, task_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [IDX_W:0]    rem_ff, rem_in;
   logic [32:0]       quo_ff, quo_in;
   logic [65:0]       prod_ff, prod_in;
   logic signed [37:0] brack_ff, brack_in;
   logic [52:0]       plo_ff, plo_in;
   logic [52:0]       phi_ff, phi_in;
   logic [VAL_W-1:0]  nv_ff, nv_in;
   logic [32:0]       dm_ff, dm_in;
   logic [63:0]       sq_ff, sq_in;
   logic              ovf_ff, ovf_in;
   logic [63:0]       sum_ff, sum_in;
   logic [63:0]       sx_ff, sx_in;
   logic [63:0]       res_ff, res_in;
   logic [63:0]       bit_ff, bit_in;
   logic              ovalid_ff, ovalid_in;
   logic [RSP_DATA_W-1:0] odata_ff, odata_in;
   logic              olast_ff, olast_in;

   logic [IDX_W-1:0]  r;
   logic [32:0]       num;
   logic              num_bit;
   logic [IDX_W:0]    trial;
   logic signed [32:0] d;
   logic [32:0]       dmag;
   logic [33:0]       q;
   logic signed [37:0] t1;
   logic [36:0]       m;
   logic [69:0]       gsum;
   logic [39:0]       ch;
   logic signed [41:0] nv_wide;
   logic signed [VAL_W-1:0] nv_sat;
   logic signed [33:0] diff;
   logic [64:0]       acc;
   logic [63:0]       rb;
   logic              out_free;

   assign r        = task_ff.k - 1'b1;
   assign num      = 33'h1_0000_0000 + 33'(r >> 1);
   assign num_bit  = num[6'd32 - cnt_ff];
   assign trial    = {rem_ff[IDX_W-1:0], num_bit};
   assign d        = 33'(task_ff.x) - 33'(task_ff.a);
   assign dmag     = d[32] ? 33'(-d) : 33'(d);
   assign q        = 34'((prod_ff + 66'h8000_0000) >> 32);
   assign t1       = d[32] ? -38'(q) : 38'(q);
   assign m        = brack_ff[37] ? 37'(-brack_ff) : 37'(brack_ff);
   assign gsum     = {1'b0, phi_ff, 16'b0} + 70'(plo_ff) + 70'h2000_0000;
   assign ch       = gsum[69:30];
   assign nv_wide  = brack_ff[37] ? 42'(task_ff.b) - 42'(ch) : 42'(task_ff.b) + 42'(ch);
   assign nv_sat   = (nv_wide > SAT_HI) ? VAL_W'(SAT_HI) :
                     (nv_wide < SAT_LO) ? VAL_W'(SAT_LO) : VAL_W'(nv_wide);
   assign diff     = 34'(nv_sat) - 34'(task_ff.b);
   assign acc      = 65'(sum_ff) + 65'(sq_ff);
   assign rb       = res_ff + bit_ff;
   assign out_free = !ovalid_ff || rsp_tready;

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;

   always_comb begin
      state_in  = state_ff;
      task_in   = task_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      prod_in   = prod_ff;
      brack_in  = brack_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      nv_in     = nv_ff;
      dm_in     = dm_ff;
      sq_in     = sq_ff;
      ovf_in    = ovf_ff;
      sum_in    = sum_ff;
      sx_in     = sx_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      q_pop     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               task_in = q_head;
               if (q_head.k == '0) begin
                  // point 0 gives nothing until its neighbour arrives
                  if (q_head.last) begin
                     sx_in    = sum_ff;
                     res_in   = '0;
                     bit_in   = 64'h4000_0000_0000_0000;
                     cnt_in   = '0;
                     state_in = ST_SQRT;
                  end
               end else if (q_head.k == IDX_W'(1)) begin
                  // mirrored rule at the center
                  brack_in = 38'sd2 * (38'(q_head.x) - 38'(q_head.b));
                  state_in = ST_GMUL1;
               end else begin
                  rem_in   = '0;
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division for the rounded reciprocal of r
            if (trial >= {1'b0, r}) begin
               rem_in = trial - {1'b0, r};
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd32) begin
               state_in = ST_MULQ;
            end
         end
         ST_MULQ: begin
            prod_in  = 66'(dmag) * 66'(quo_ff);
            state_in = ST_BRACK;
         end
         ST_BRACK: begin
            brack_in = t1 + 38'(task_ff.x) + 38'(task_ff.a) - 38'sd2 * 38'(task_ff.b);
            state_in = ST_GMUL1;
         end
         ST_GMUL1: begin
            plo_in   = 53'(m) * 53'(gain[15:0]);
            state_in = ST_GMUL2;
         end
         ST_GMUL2: begin
            phi_in   = 53'(m) * 53'(gain[31:16]);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            nv_in    = nv_sat;
            dm_in    = diff[33] ? 33'(-diff) : 33'(diff);
            state_in = (task_ff.k == IDX_W'(1)) ? ST_EMIT : ST_SQ;
         end
         ST_SQ: begin
            sq_in    = 64'(dm_ff[31:0]) * 64'(dm_ff[31:0]);
            ovf_in   = dm_ff[32];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (ovf_ff || acc[64]) begin
               sum_in = '1;
            end else begin
               sum_in = acc[63:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = RSP_DATA_W'({32'b0, r, nv_ff});
               olast_in  = 1'b0;
               if (task_ff.last) begin
                  sx_in    = sum_ff;
                  res_in   = '0;
                  bit_in   = 64'h4000_0000_0000_0000;
                  cnt_in   = '0;
                  state_in = ST_SQRT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SQRT: begin
            if (sx_ff >= rb) begin
               sx_in  = sx_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_EMITF;
            end
         end
         ST_EMITF: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = RSP_DATA_W'({res_ff[31:0], task_ff.k, task_ff.x});
               olast_in  = 1'b1;
               sum_in    = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      task_ff  <= task_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      prod_ff  <= prod_in;
      brack_ff <= brack_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      nv_ff    <= nv_in;
      dm_ff    <= dm_in;
      sq_ff    <= sq_in;
      ovf_ff   <= ovf_in;
      sx_ff    <= sx_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule : rhfs_back
`default_nettype wire

// ===== hw/rtl/radial_heat_ftcs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radial_heat_ftcs_step
// One explicit time step of radial diffusion in a sphere, one point a transfer.
// ----------------------------------------------------------------------------
// Samples stream in point 0 first; the update of a point leaves once its
// right neighbour has arrived, and the outermost point (tlast) leaves unchanged
// with the step error in its result. A two-entry queue decouples intake from
// the arithmetic sequencer. Inner points pass through a 33-step bit-serial
// reciprocal divider followed by the product, bracket, two gain multiplies,
// apply, square, accumulate and emit steps; point 1 skips the divider,
// product, bracket, square and accumulate, point 0 is only taken from the
// queue, and the outermost point adds a 32-step square root and an emit step.
module radial_heat_ftcs_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [rhfs_pkg::GAIN_W-1:0]     csr_wr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rhfs_pkg::VAL_W-1:0]      req_tdata,  // sample_value
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // new_value[31:0], point_index[43:32], step_error[75:44], zero fill
   output logic [rhfs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import rhfs_pkg::*;

   logic [GAIN_W-1:0] gain_ff;
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_not_empty;
   task_type          push_task;
   task_type          head_task;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   rhfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_task     (push_task)
   );

   rhfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_task (push_task),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_task)
   );

   rhfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .gain        (gain_ff),
      .q_not_empty (q_not_empty),
      .q_head      (head_task),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule : radial_heat_ftcs_step
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radial heat step block: streams grid steps,
// predicts each updated point in fixed point and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import rhfs_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [11:0] index;
      logic [31:0] err;
      logic        fin;
   } point_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tlast;

   point_result_type pending_points[$];
   int  errors = 0;
   bit  idle_off = 0;
   bit  hold_rsp = 0;
   int  hold_cycles = 0;

   // model state
   logic [31:0]  gain = GAIN_RESET;
   longint       prev2 = 0, prev1 = 0;
   int           count = 0;
   logic [63:0]  sq_sum = 0;

   always #4 clock = ~clock;

   radial_heat_ftcs_step dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint scaled_change(longint mid, longint bracket);
      logic [63:0] m, gh, gl, lo, hi, q;
      m  = bracket < 0 ? -bracket : bracket;
      gh = gain >> 16;
      gl = gain & 32'hFFFF;
      lo = m * gl + (64'd1 << 29);
      hi = m * gh;
      q  = (hi >> 14) + ((((hi & 64'h3FFF) << 16) + lo) >> 30);
      return clamp32(mid + (bracket < 0 ? -longint'(q) : longint'(q)));
   endfunction

   function automatic logic [31:0] root64(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res[31:0];
   endfunction

   task automatic predict_point(logic [31:0] raw, logic lst);
      longint x, nv, d, t1, dm, xs;
      logic [63:0] rcp, q, sq;
      int r;
      bit fin;
      point_result_type e;
      x = longint'(signed'(raw));
      fin = lst || count >= MAX_POINTS - 1;
      if (count >= 1) begin
         r = count - 1;
         if (r == 0) begin
            nv = scaled_change(prev1, 2 * x - 2 * prev1);
         end else begin
            d = x - prev2;
            rcp = ((64'd1 << 32) + (r >> 1)) / r;
            q = ((d < 0 ? -d : d) * rcp + (64'd1 << 31)) >> 32;
            t1 = d < 0 ? -longint'(q) : longint'(q);
            nv = scaled_change(prev1, t1 + x + prev2 - 2 * prev1);
            dm = nv - prev1;
            if (dm < 0) dm = -dm;
            if (dm >= 64'sd4294967296) begin
               sq_sum = '1;
            end else begin
               sq = dm * dm;
               sq_sum = (sq_sum > ~64'd0 - sq) ? '1 : sq_sum + sq;
            end
         end
         e.value = nv[31:0]; e.index = 12'(r); e.err = '0; e.fin = 1'b0;
         pending_points.push_back(e);
      end
      if (fin) begin
         xs = clamp32(x);
         e.value = xs[31:0]; e.index = 12'(count); e.err = root64(sq_sum); e.fin = 1'b1;
         pending_points.push_back(e);
         prev2 = 0; prev1 = 0; count = 0; sq_sum = 0;
      end else begin
         prev2 = prev1; prev1 = x; count++;
      end
   endtask

   task automatic send_sample(logic [31:0] v, logic lst);
      if (!idle_off && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_point(v, lst);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_gain(logic [31:0] g);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gain = g;
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_grid(int n);
      for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
   endtask

   task automatic test_directed();
      send_sample(32'h00010000, 1'b1);          // single point step
      send_sample(32'h7FFFFFFF, 1'b0);          // two point step
      send_sample(32'h80000000, 1'b1);
      send_sample(32'h80000000, 1'b0);
      send_sample(32'h7FFFFFFF, 1'b0);
      send_sample(32'h80000000, 1'b0);
      send_sample(32'h7FFFFFFF, 1'b0);
      send_sample(32'hFFFFFFFF, 1'b1);
      for (int i = 0; i < 6; i++) send_sample(32'h00010000 * i, i == 5);
   endtask

   task automatic test_gain_sweep();
      logic [31:0] gains[4] = '{32'h0, 32'hFFFFFFFF, 32'h40000000, 32'h00000001};
      foreach (gains[i]) begin
         set_gain(gains[i]);
         send_grid(4);
         send_grid(7);
      end
      set_gain(GAIN_RESET);
   endtask

   // the last stretch runs with no idling on either side
   task automatic test_random();
      int sent = 0, n;
      while (sent < 400) begin
         if (sent >= 320) idle_off = 1;
         n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 20);
         send_grid(n);
         sent += n;
         if ($urandom_range(0, 7) == 0) begin
            set_gain($urandom);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      hold_rsp = 1;
      send_grid(12);
      drain_results();                          // sender pauses until all come back
      wait (hold_rsp == 0);
   endtask

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
         if (hold_cycles == 0) hold_rsp <= 0;
         else hold_cycles <= hold_cycles - 1;
      end else if (idle_off) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= $urandom_range(0, 4) != 0;
      end
   end

   always @(posedge clock) begin
      point_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            $display("%t unexpected transfer: actual %h last %b", $realtime, rsp_tdata,
                     rsp_tlast);
            errors++;
         end else begin
            e = pending_points.pop_front();
            if (rsp_tdata[31:0] !== e.value || rsp_tdata[43:32] !== e.index ||
                rsp_tdata[75:44] !== e.err || rsp_tlast !== e.fin) begin
               $display("%t mismatch: expected %h %0d %h %b, actual %h %0d %h %b",
                        $realtime, e.value, e.index, e.err, e.fin, rsp_tdata[31:0],
                        rsp_tdata[43:32], rsp_tdata[75:44], rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_gain_sweep();
      test_backpressure();
      test_random();
      drain_results();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
